// File: sv/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg: shared types and constants for the relay PID autotuner
// Configuration record, controller/datapath command and status groups,
// arithmetic sequence codes and fixed widths.
// ----------------------------------------------------------------------------
package rpa_pkg;

   // Fractional bits of the Q-format gains
   localparam int GAIN_FRAC_BITS = 16;

   localparam int TIME_W   = 27;   // millisecond accumulators
   localparam int AMP_W    = 22;   // amplitude accumulator, 1/16 degree
   localparam int CNT_W    = 7;    // measured period count
   localparam int GAIN_W   = 32;

   // Shared shift-add multiplier / restoring divider
   localparam int ACC_W     = 96;  // product and dividend width
   localparam int DVS_W     = 48;  // divisor width
   localparam int QUO_W     = 64;  // kept quotient bits
   localparam int MUL_STEPS = 32;  // one multiplier bit per cycle
   localparam int DIV_STEPS = ACC_W;
   localparam int ITER_W    = $clog2(DIV_STEPS);

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [AMP_W-1:0]  AMP_MAX  = {AMP_W{1'b1}};

   typedef enum logic [1:0] {
      PH_RAMP  = 2'd0,
      PH_CYCLE = 2'd1,
      PH_DONE  = 2'd2,
      PH_FAIL  = 2'd3
   } phase_type;

   // Gain computation sequence: multiplies on even codes, divides on odd
   typedef enum logic [2:0] {
      OP_MUL_NUM = 3'd0,
      OP_DIV_KP  = 3'd1,
      OP_MUL_GI  = 3'd2,
      OP_DIV_GI  = 3'd3,
      OP_MUL_GD  = 3'd4,
      OP_DIV_GD  = 3'd5
   } op_type;

   // Register index (byte address / 4)
   typedef enum logic [2:0] {
      REG_TARGET  = 3'd0,
      REG_HYST    = 3'd1,
      REG_POWER   = 3'd2,
      REG_CYCLES  = 3'd3,
      REG_METHOD  = 3'd4,
      REG_TIMEOUT = 3'd5
   } reg_type;

   typedef struct packed {
      logic [14:0] target;
      logic [9:0]  hyst;
      logic [7:0]  power;
      logic [6:0]  cycles;
      logic        method;
      logic [15:0] timeout;
   } cfg_type;

   typedef struct packed {
      logic   step;
      logic   fail;
      logic   load;
      logic   iter;
      logic   store;
      logic   emit;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic finish_needed;
      logic bad_avg;
      logic rsp_free;
   } status_type;

endpackage

// File: sv/rpa_csr.sv
// ----------------------------------------------------------------------------
// rpa_csr: configuration registers
// APB-style write/read port holding the six tuning registers.
// ----------------------------------------------------------------------------
module rpa_csr import rpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   reg_type idx;
   logic    wr_en;

   assign idx        = reg_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_TARGET:  cfg_in.target  = csr_pwdata[14:0];
            REG_HYST:    cfg_in.hyst    = csr_pwdata[9:0];
            REG_POWER:   cfg_in.power   = csr_pwdata[7:0];
            REG_CYCLES:  cfg_in.cycles  = csr_pwdata[6:0];
            REG_METHOD:  cfg_in.method  = csr_pwdata[0];
            REG_TIMEOUT: cfg_in.timeout = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_TARGET:  csr_prdata = {17'd0, cfg_ff.target};
         REG_HYST:    csr_prdata = {22'd0, cfg_ff.hyst};
         REG_POWER:   csr_prdata = {24'd0, cfg_ff.power};
         REG_CYCLES:  csr_prdata = {25'd0, cfg_ff.cycles};
         REG_METHOD:  csr_prdata = {31'd0, cfg_ff.method};
         REG_TIMEOUT: csr_prdata = {16'd0, cfg_ff.timeout};
         default:     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target  <= 15'd3200;
         cfg_ff.hyst    <= 10'd16;
         cfg_ff.power   <= 8'd255;
         cfg_ff.cycles  <= 7'd5;
         cfg_ff.method  <= 1'b0;
         cfg_ff.timeout <= 16'd600;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/rpa_datapath.sv
// ----------------------------------------------------------------------------
// rpa_datapath: tuning state, relay step, gain arithmetic, result register
// Applies one sample per step command and runs the shared shift-add
// multiplier / restoring divider under controller command.
// ----------------------------------------------------------------------------
module rpa_datapath import rpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_load,
   input  logic               req_kind,
   input  logic signed [15:0] req_temperature,
   input  logic [15:0]        req_delta_ms,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [7:0]         rsp_drive,
   output logic [1:0]         rsp_run_status,
   output logic [31:0]        rsp_gain_p,
   output logic [31:0]        rsp_gain_i,
   output logic [31:0]        rsp_gain_d
);

   // latched transaction
   logic               kind_ff;
   logic signed [15:0] temp_ff;
   logic [15:0]        dms_ff;

   // tuning state
   phase_type          phase_ff, phase_in;
   logic               relay_ff, relay_in;
   logic [7:0]         cidx_ff, cidx_in;
   logic signed [15:0] crest_ff, crest_in, trough_ff, trough_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in, pstart_ff, pstart_in, ptot_ff, ptot_in;
   logic [AMP_W-1:0]   atot_ff, atot_in;
   logic [CNT_W-1:0]   mcnt_ff, mcnt_in;
   logic [GAIN_W-1:0]  gp_ff, gp_in, gi_ff, gi_in, gd_ff, gd_in;

   // arithmetic unit
   logic [ACC_W-1:0]   a_ff, a_in, prod_ff, prod_in, dvd_ff, dvd_in;
   logic [31:0]        b_ff, b_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in, rem_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in, kpw_ff, kpw_in;
   logic               ovf_ff, ovf_in;
   logic [GAIN_W-1:0]  gis_ff, gis_in;

   // result register
   logic               rv_ff, rv_in;
   logic [7:0]         rdrive_ff, rdrive_in;
   logic [1:0]         rstat_ff, rstat_in;
   logic [GAIN_W-1:0]  rgp_ff, rgp_in, rgi_ff, rgi_in, rgd_ff, rgd_in;

   // step terms
   logic signed [16:0]  upper, lower, temp_x, amp;
   logic signed [15:0]  crest_n, trough_n, tgt_s;
   logic [TIME_W:0]     el_sum, pt_sum;
   logic [TIME_W-1:0]   el, per;
   logic [25:0]         limit;
   logic [AMP_W:0]      at_sum;
   logic [15:0]         amp_c;
   logic                active;

   // operand terms
   logic [30:0]         kcp;
   logic [40:0]         den;
   logic [20:0]         mul_i;
   logic [31:0]         div_i;
   logic [19:0]         div_d;
   logic [31:0]         s1000, n16;
   logic [DVS_W:0]      rem_sh;
   logic                qb;
   logic [GAIN_W-1:0]   q_sat;

   assign active = (phase_ff == PH_RAMP) || (phase_ff == PH_CYCLE);
   assign tgt_s  = signed'({1'b0, cfg.target});
   assign upper  = signed'({2'b00, cfg.target}) + signed'({7'd0, cfg.hyst});
   assign lower  = signed'({2'b00, cfg.target}) - signed'({7'd0, cfg.hyst});
   assign temp_x = {temp_ff[15], temp_ff};
   assign el_sum = {1'b0, elapsed_ff} + {{(TIME_W-15){1'b0}}, dms_ff};
   assign el     = el_sum[TIME_W] ? TIME_MAX : el_sum[TIME_W-1:0];
   assign limit  = 26'({10'd0, cfg.timeout} * 26'd1000);
   assign crest_n  = (temp_ff > crest_ff) ? temp_ff : crest_ff;
   assign trough_n = (temp_ff < trough_ff) ? temp_ff : trough_ff;
   assign per    = el - pstart_ff;
   assign amp    = {crest_n[15], crest_n} - {trough_n[15], trough_n};
   assign amp_c  = amp[16] ? 16'd0 : amp[15:0];
   assign pt_sum = {1'b0, ptot_ff} + {1'b0, per};
   assign at_sum = {1'b0, atot_ff} + {{(AMP_W-15){1'b0}}, amp_c};

   // operands for the gain sequence
   assign kcp   = (cfg.method ? 31'd5760000 : 31'd7680000) * {23'd0, cfg.power};
   assign den   = {19'd0, atot_ff} * 41'd314159;
   assign mul_i = {14'd0, mcnt_ff} * (cfg.method ? 21'd10000 : 21'd2000);
   assign div_i = cfg.method ? ({5'd0, ptot_ff} * 32'd22) : {5'd0, ptot_ff};
   assign div_d = {13'd0, mcnt_ff} * (cfg.method ? 20'd6300 : 20'd8000);

   // average checks
   assign s1000 = {10'd0, atot_ff} * 32'd1000;
   assign n16   = {21'd0, mcnt_ff, 4'd0};
   assign status.finish_needed = !kind_ff && active && (mcnt_ff >= cfg.cycles);
   assign status.bad_avg = (mcnt_ff == '0) || (s1000 <= n16) ||
                           (ptot_ff <= {{(TIME_W-CNT_W){1'b0}}, mcnt_ff});
   assign status.rsp_free = !rv_ff || rsp_ready;

   // restoring divide step
   assign rem_sh = {rem_ff, dvd_ff[ACC_W-1]};
   assign qb     = rem_sh >= {1'b0, dvs_ff};
   assign q_sat  = (ovf_ff || (|quo_ff[QUO_W-1:GAIN_W])) ? '1 : quo_ff[GAIN_W-1:0];

   // tuning state update
   always_comb begin
      phase_in = phase_ff;   relay_in = relay_ff;   cidx_in = cidx_ff;
      crest_in = crest_ff;   trough_in = trough_ff; elapsed_in = elapsed_ff;
      pstart_in = pstart_ff; ptot_in = ptot_ff;     atot_in = atot_ff;
      mcnt_in = mcnt_ff;     gp_in = gp_ff;         gi_in = gi_ff;   gd_in = gd_ff;
      if (cmd.step) begin
         if (kind_ff) begin
            phase_in = PH_RAMP;   relay_in = 1'b1;  cidx_in = '0;
            crest_in = tgt_s;     trough_in = tgt_s;
            elapsed_in = '0;      pstart_in = '0;   ptot_in = '0;
            atot_in = '0;         mcnt_in = '0;
            gp_in = '0;           gi_in = '0;       gd_in = '0;
         end else if (active) begin
            elapsed_in = el;
            if ({1'b0, el} > {2'b00, limit}) begin
               phase_in = PH_FAIL;
            end else begin
               crest_in  = crest_n;
               trough_in = trough_n;
               if (relay_ff && (temp_x >= upper)) begin
                  relay_in = 1'b0;
                  if (phase_ff == PH_RAMP) begin
                     phase_in = PH_CYCLE;
                  end else begin
                     // one full period ends; the first is not measured
                     if (cidx_ff != 8'd0) begin
                        ptot_in = pt_sum[TIME_W] ? TIME_MAX : pt_sum[TIME_W-1:0];
                        atot_in = at_sum[AMP_W] ? AMP_MAX : at_sum[AMP_W-1:0];
                        mcnt_in = mcnt_ff + 1'b1;
                     end
                     if (cidx_ff != 8'hFF) begin
                        cidx_in = cidx_ff + 1'b1;
                     end
                  end
                  pstart_in = el;
                  trough_in = temp_ff;
               end else if (!relay_ff && (temp_x <= lower)) begin
                  relay_in = 1'b1;
                  crest_in = temp_ff;
               end
            end
         end
      end
      if (cmd.fail) begin
         phase_in = PH_FAIL;
      end
      if (cmd.store && (cmd.op == OP_DIV_GD)) begin
         gp_in    = (|kpw_ff[QUO_W-1:GAIN_W]) ? '1 : kpw_ff[GAIN_W-1:0];
         gi_in    = gis_ff;
         gd_in    = q_sat;
         phase_in = PH_DONE;
      end
   end

   // shared multiplier / divider
   always_comb begin
      a_in = a_ff;     b_in = b_ff;     prod_in = prod_ff;  dvd_in = dvd_ff;
      dvs_in = dvs_ff; rem_in = rem_ff; quo_in = quo_ff;    ovf_in = ovf_ff;
      kpw_in = kpw_ff; gis_in = gis_ff;
      if (cmd.load) begin
         rem_in = '0;
         quo_in = '0;
         ovf_in = 1'b0;
         case (cmd.op)
            OP_MUL_NUM: begin
               a_in = {{(ACC_W-31){1'b0}}, kcp};
               b_in = {25'd0, mcnt_ff};
               prod_in = '0;
            end
            OP_DIV_KP: begin
               dvd_in = prod_ff << GAIN_FRAC_BITS;
               dvs_in = {{(DVS_W-41){1'b0}}, den};
            end
            OP_MUL_GI: begin
               a_in = {{(ACC_W-QUO_W){1'b0}}, kpw_ff};
               b_in = {11'd0, mul_i};
               prod_in = '0;
            end
            OP_DIV_GI: begin
               dvd_in = prod_ff;
               dvs_in = {{(DVS_W-32){1'b0}}, div_i};
            end
            OP_MUL_GD: begin
               a_in = {{(ACC_W-QUO_W){1'b0}}, kpw_ff};
               b_in = {{(32-TIME_W){1'b0}}, ptot_ff};
               prod_in = '0;
            end
            OP_DIV_GD: begin
               dvd_in = prod_ff;
               dvs_in = {{(DVS_W-20){1'b0}}, div_d};
            end
            default: ;
         endcase
      end
      if (cmd.iter) begin
         if ((cmd.op == OP_MUL_NUM) || (cmd.op == OP_MUL_GI) || (cmd.op == OP_MUL_GD)) begin
            prod_in = prod_ff + (b_ff[0] ? a_ff : '0);
            a_in    = a_ff << 1;
            b_in    = b_ff >> 1;
         end else begin
            rem_in = qb ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DVS_W-1:0];
            dvd_in = dvd_ff << 1;
            quo_in = {quo_ff[QUO_W-2:0], qb};
            ovf_in = ovf_ff | quo_ff[QUO_W-1];
         end
      end
      if (cmd.store) begin
         case (cmd.op)
            OP_DIV_KP: kpw_in = quo_ff;
            OP_DIV_GI: gis_in = q_sat;
            default: ;
         endcase
      end
   end

   // result register
   always_comb begin
      rv_in = rv_ff;   rdrive_in = rdrive_ff; rstat_in = rstat_ff;
      rgp_in = rgp_ff; rgi_in = rgi_ff;       rgd_in = rgd_ff;
      if (cmd.emit) begin
         rv_in     = 1'b1;
         rdrive_in = (!kind_ff && relay_ff && active) ? cfg.power : 8'd0;
         rstat_in  = phase_ff;
         rgp_in    = gp_ff;
         rgi_in    = gi_ff;
         rgd_in    = gd_ff;
      end else if (rsp_ready) begin
         rv_in = 1'b0;
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_drive      = rdrive_ff;
   assign rsp_run_status = rstat_ff;
   assign rsp_gain_p     = rgp_ff;
   assign rsp_gain_i     = rgi_ff;
   assign rsp_gain_d     = rgd_ff;

   // payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         temp_ff <= req_temperature;
         dms_ff  <= req_delta_ms;
      end
      a_ff <= a_in;     b_ff <= b_in;     prod_ff <= prod_in; dvd_ff <= dvd_in;
      dvs_ff <= dvs_in; rem_ff <= rem_in; quo_ff <= quo_in;   ovf_ff <= ovf_in;
      kpw_ff <= kpw_in; gis_ff <= gis_in;
      rdrive_ff <= rdrive_in; rstat_ff <= rstat_in;
      rgp_ff <= rgp_in; rgi_ff <= rgi_in; rgd_ff <= rgd_in;
   end

   // control and tuning state
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 1'b0;
         phase_ff <= PH_RAMP;   relay_ff <= 1'b1;  cidx_ff <= '0;
         crest_ff <= 16'sd3200; trough_ff <= 16'sd3200;
         elapsed_ff <= '0;      pstart_ff <= '0;   ptot_ff <= '0;
         atot_ff <= '0;         mcnt_ff <= '0;
         gp_ff <= '0;           gi_ff <= '0;       gd_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (in_load) begin
            kind_ff <= req_kind;
         end
         phase_ff <= phase_in;     relay_ff <= relay_in;   cidx_ff <= cidx_in;
         crest_ff <= crest_in;     trough_ff <= trough_in;
         elapsed_ff <= elapsed_in; pstart_ff <= pstart_in; ptot_ff <= ptot_in;
         atot_ff <= atot_in;       mcnt_ff <= mcnt_in;
         gp_ff <= gp_in;           gi_ff <= gi_in;         gd_ff <= gd_in;
         rv_ff <= rv_in;
      end
   end

endmodule

// File: sv/rpa_ctrl.sv
// ----------------------------------------------------------------------------
// rpa_ctrl: sequencing state machine
// Steps one transaction, then runs the six-operation gain sequence on the
// shared unit when enough periods are measured and their averages pass.
// ----------------------------------------------------------------------------
module rpa_ctrl import rpa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_STEP  = 8'b0000_0010,
      ST_CHECK = 8'b0000_0100,
      ST_LOAD  = 8'b0000_1000,
      ST_MUL   = 8'b0001_0000,
      ST_DIV   = 8'b0010_0000,
      ST_STORE = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.op    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.finish_needed && status.bad_avg) begin
               cmd.fail = 1'b1;
               state_in = ST_EMIT;
            end else if (status.finish_needed) begin
               op_in    = OP_MUL_NUM;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = '0;
            if ((op_ff == OP_MUL_NUM) || (op_ff == OP_MUL_GI) || (op_ff == OP_MUL_GD)) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_MUL: begin
            cmd.iter = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == ITER_W'(MUL_STEPS - 1)) begin
               op_in    = op_type'(op_ff + 3'd1);
               state_in = ST_LOAD;
            end
         end
         ST_DIV: begin
            cmd.iter = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == ITER_W'(DIV_STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (op_ff == OP_DIV_GD) begin
               state_in = ST_EMIT;
            end else begin
               op_in    = op_type'(op_ff + 3'd1);
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_MUL_NUM;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
      end
   end

   // an accepted transaction is always stepped next
   a_accept_step: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_STEP))
      else $error("accepted transaction not stepped");

   // last divide store leads straight to the result
   a_last_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE && op_ff == OP_DIV_GD) |=> (state_ff == ST_EMIT))
      else $error("gain sequence did not end in emit");

   // no arithmetic when no finish is due
   a_no_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && !status.finish_needed) |=> (state_ff == ST_EMIT))
      else $error("arithmetic started without finish");

   // emit only when the result register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.rsp_free)
      else $error("result overwritten");

endmodule

// File: sv/relay_pid_autotuner_core.sv
// ----------------------------------------------------------------------------
// relay_pid_autotuner_core: relay-feedback PID autotuner
// Relay control around a setpoint, period/amplitude measurement and
// Ziegler-Nichols / Tyreus-Luyben gain calculation in fixed point.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    kind, temperature, delta_ms
//  rsp      out        rsp_valid/rsp_ready    drive, run_status, gain_p/i/d
//  csr      in/out     psel/penable/pready    paddr, pwdata, prdata
//
//  A transaction passes the step, check and emit states when no gains are due.
//  The transaction that completes the measurement adds three multiplies and
//  three divides (one bit per cycle on the shared unit) via load/iterate states.
//  Reset is synchronous; state returns to the heating ramp with default
//  registers. One result may wait in the output register while the next
//  transaction is accepted and stepped.
// ----------------------------------------------------------------------------
module relay_pid_autotuner_core import rpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic signed [15:0] req_temperature,
   input  logic [15:0]        req_delta_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_drive,
   output logic [1:0]         rsp_run_status,
   output logic [31:0]        rsp_gain_p,
   output logic [31:0]        rsp_gain_i,
   output logic [31:0]        rsp_gain_d,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       in_load;

   assign in_load = req_valid && req_ready;

   rpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rpa_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .in_load         (in_load),
      .req_kind        (req_kind),
      .req_temperature (req_temperature),
      .req_delta_ms    (req_delta_ms),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_drive       (rsp_drive),
      .rsp_run_status  (rsp_run_status),
      .rsp_gain_p      (rsp_gain_p),
      .rsp_gain_i      (rsp_gain_i),
      .rsp_gain_d      (rsp_gain_d)
   );

endmodule

// File: test/relay_pid_autotuner_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// relay_pid_autotuner_core_tb: self-checking bench for the relay PID autotuner
// Runs phases of register settings, each relay oscillation sequences with
// random content, most after a restart, and compares every result against an
// in-bench prediction of the relay, period measurement and gain arithmetic.
// ----------------------------------------------------------------------------
module relay_pid_autotuner_core_tb;
   import rpa_pkg::*;

   typedef struct {
      logic        kind;
      logic [15:0] temp;
      logic [15:0] dms;
   } sample_type;

   typedef struct {
      logic [7:0]  drive;
      logic [1:0]  status;
      logic [31:0] gp;
      logic [31:0] gi;
      logic [31:0] gd;
   } tune_result_type;

   localparam longint unsigned SAT32 = 64'hFFFF_FFFF;
   localparam longint unsigned BIG   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int unsigned T_MAX = 134217727;
   localparam int unsigned A_MAX = 4194303;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready, req_kind = 0;
   logic signed [15:0] req_temperature = 0;
   logic [15:0] req_delta_ms = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [7:0] rsp_drive;
   logic [1:0] rsp_run_status;
   logic [31:0] rsp_gain_p, rsp_gain_i, rsp_gain_d;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   relay_pid_autotuner_core i_dut (.*);

   // Shadow registers and tuner state
   int unsigned sh_target, sh_hyst, sh_power, sh_cycles, sh_method, sh_timeout;
   phase_type   tn_phase;
   bit          tn_relay;
   int unsigned tn_cycle_idx, tn_elapsed, tn_pstart, tn_ptotal, tn_atotal, tn_count;
   int          tn_crest, tn_trough;
   logic [31:0] tn_gains [3];

   sample_type      pending_samples[$];
   tune_result_type expected_results[$];
   int  mismatches = 0;
   int  unmatched  = 0;
   bit  no_idle    = 0;
   int  send_gap   = 0;
   int  ready_stall = 0;
   int  item_total = 0;
   bit  req_valid_taken = 0;
   bit  rsp_valid_taken = 0;

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // floor(a*b/c) clipped to limit
   function automatic longint unsigned scaled_quot(longint unsigned a, longint unsigned b,
                                                    longint unsigned c, longint unsigned lim);
      longint unsigned q, r, s;
      if (c == 0) return lim;
      if (b == 0) return 0;
      q = a / c;
      r = a % c;
      if (q > lim / b) return lim;
      s = q * b + (r * b) / c;
      return (s > lim) ? lim : s;
   endfunction

   function automatic void tuner_restart();
      tn_phase = PH_RAMP;
      tn_relay = 1;
      tn_cycle_idx = 0;
      tn_crest = sh_target;
      tn_trough = sh_target;
      tn_elapsed = 0;
      tn_pstart = 0;
      tn_ptotal = 0;
      tn_atotal = 0;
      tn_count = 0;
      foreach (tn_gains[k]) tn_gains[k] = 0;
   endfunction

   // Gain calculation at the end of measurement
   function automatic void compute_gains();
      longint unsigned n, s, t, kc, kpw, gi, gd;
      n = tn_count;
      s = tn_atotal;
      t = tn_ptotal;
      if (n == 0 || s * 1000 <= n * 16 || t <= n) begin
         tn_phase = PH_FAIL;
         return;
      end
      kc = sh_method ? 5760000 : 7680000;
      kpw = scaled_quot(kc * sh_power * n, 64'd1 << GAIN_FRAC_BITS, 314159 * s, BIG);
      if (sh_method) begin
         gi = scaled_quot(kpw, 10000 * n, 22 * t, SAT32);
         gd = scaled_quot(kpw, t, 6300 * n, SAT32);
      end else begin
         gi = scaled_quot(kpw, 2000 * n, t, SAT32);
         gd = scaled_quot(kpw, t, 8000 * n, SAT32);
      end
      tn_gains[0] = (kpw > SAT32) ? SAT32[31:0] : kpw[31:0];
      tn_gains[1] = gi[31:0];
      tn_gains[2] = gd[31:0];
      tn_phase = PH_DONE;
   endfunction

   // Advance the tuner by one transaction and return the expected result
   function automatic tune_result_type tuner_step(sample_type x);
      tune_result_type res;
      int temp, upper, lower, amp;
      int unsigned per;
      bit on_drive;
      temp = $signed(x.temp);
      upper = sh_target + sh_hyst;
      lower = int'(sh_target) - int'(sh_hyst);
      on_drive = 0;
      if (x.kind) begin
         tuner_restart();
      end else if (tn_phase == PH_RAMP || tn_phase == PH_CYCLE) begin
         tn_elapsed += x.dms;
         if (tn_elapsed > T_MAX) tn_elapsed = T_MAX;
         if (longint'(tn_elapsed) > longint'(sh_timeout) * 1000) begin
            tn_phase = PH_FAIL;
         end else begin
            if (temp > tn_crest) tn_crest = temp;
            if (temp < tn_trough) tn_trough = temp;
            if (tn_relay && temp >= upper) begin
               tn_relay = 0;
               if (tn_phase == PH_RAMP) begin
                  tn_phase = PH_CYCLE;
               end else begin
                  per = (tn_elapsed - tn_pstart) & T_MAX;
                  amp = tn_crest - tn_trough;
                  if (amp < 0) amp = 0;
                  if (tn_cycle_idx > 0) begin
                     tn_ptotal += per;
                     if (tn_ptotal > T_MAX) tn_ptotal = T_MAX;
                     tn_atotal += amp;
                     if (tn_atotal > A_MAX) tn_atotal = A_MAX;
                     tn_count = (tn_count + 1) & 7'h7F;
                  end
                  if (tn_cycle_idx < 255) tn_cycle_idx++;
               end
               tn_pstart = tn_elapsed;
               tn_trough = temp;
            end else if (!tn_relay && temp <= lower) begin
               tn_relay = 1;
               tn_crest = temp;
            end
            if (tn_count >= sh_cycles) compute_gains();
            else on_drive = tn_relay;
         end
      end
      res.drive  = on_drive ? sh_power[7:0] : 8'd0;
      res.status = tn_phase;
      res.gp = tn_gains[0];
      res.gi = tn_gains[1];
      res.gd = tn_gains[2];
      return res;
   endfunction

   // Request driver
   always @(negedge clock) begin
      int draw;
      if (!reset) begin
         if (req_valid && !(req_valid_taken)) begin
            // hold until accepted
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 0;
         end else if (pending_samples.size() > 0) begin
            sample_type x;
            x = pending_samples.pop_front();
            req_valid <= 1;
            req_kind <= x.kind;
            req_temperature <= x.temp;
            req_delta_ms <= x.dms;
            send_gap <= no_idle ? 0 : $urandom_range(0, 4);
         end else begin
            req_valid <= 0;
         end
         // result-side stalls
         if (rsp_valid_taken) begin
            draw = no_idle ? 0 : int'($urandom_range(0, 4));
            ready_stall <= draw;
            rsp_ready <= (draw == 0);
         end else if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            rsp_ready <= (ready_stall == 1);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // Monitor: predict on request acceptance, check on result acceptance
   always @(posedge clock) begin
      req_valid_taken = 0;
      rsp_valid_taken = 0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sample_type x;
            x.kind = req_kind;
            x.temp = req_temperature;
            x.dms  = req_delta_ms;
            expected_results.push_back(tuner_step(x));
            req_valid_taken = 1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_valid_taken = 1;
            if (expected_results.size() == 0) begin
               unmatched++;
               if (mismatches + unmatched <= 10)
                  $display("unexpected result transaction: drive %0d status %0d",
                           rsp_drive, rsp_run_status);
            end else begin
               tune_result_type e;
               e = expected_results.pop_front();
               if (e.drive !== rsp_drive || e.status !== rsp_run_status ||
                   e.gp !== rsp_gain_p || e.gi !== rsp_gain_i || e.gd !== rsp_gain_d) begin
                  mismatches++;
                  if (mismatches + unmatched <= 10)
                     $display("mismatch: exp drv %0d st %0d p %h i %h d %h, got %0d %0d %h %h %h",
                              e.drive, e.status, e.gp, e.gi, e.gd, rsp_drive,
                              rsp_run_status, rsp_gain_p, rsp_gain_i, rsp_gain_d);
               end
            end
         end
      end
   end

   task automatic csr_write(reg_type idx, int unsigned value);
      @(negedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      case (idx)
         REG_TARGET:  sh_target  = value & 16'h7FFF;
         REG_HYST:    sh_hyst    = value & 10'h3FF;
         REG_POWER:   sh_power   = value & 8'hFF;
         REG_CYCLES:  sh_cycles  = value & 7'h7F;
         REG_METHOD:  sh_method  = value & 1;
         REG_TIMEOUT: sh_timeout = value & 16'hFFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   function automatic void add_sample(bit kind, int temp, int unsigned dms);
      sample_type x;
      if (temp > 32767) temp = 32767;
      if (temp < -2048) temp = -2048;
      x.kind = kind;
      x.temp = temp[15:0];
      x.dms  = dms[15:0];
      pending_samples.push_back(x);
      item_total++;
   endfunction

   function automatic int unsigned random_delta();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 3000);
   endfunction

   // One oscillation run: optional restart, swings across the band, trailers
   function automatic void build_run(bit do_restart);
      int up, lo, pairs;
      bit flat;
      up = sh_target + sh_hyst;
      lo = int'(sh_target) - int'(sh_hyst);
      pairs = sh_cycles + 3;
      flat = ($urandom_range(0, 7) == 0);
      if (do_restart) add_sample(1, $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535));
      for (int p = 0; p < pairs; p++) begin
         if (flat) begin
            add_sample(0, sh_target, $urandom_range(0, 1));
            add_sample(0, sh_target, $urandom_range(0, 1));
         end else begin
            if ($urandom_range(0, 3) == 0)
               add_sample(0, lo + $urandom_range(0, 2 * sh_hyst), random_delta());
            add_sample(0, up + $urandom_range(0, 200), random_delta());
            if ($urandom_range(0, 3) == 0)
               add_sample(0, lo + $urandom_range(0, 2 * sh_hyst), random_delta());
            add_sample(0, lo - $urandom_range(0, 200), random_delta());
         end
         if ($urandom_range(0, 60) == 0) add_sample(1, $urandom_range(0, 65535), random_delta());
      end
      // samples after the run has ended
      for (int k = 0; k < 3; k++)
         add_sample(0, $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535));
   endfunction

   task automatic apply_settings(int unsigned tg, int unsigned hy, int unsigned pw,
                                 int unsigned cy, int unsigned me, int unsigned to);
      csr_write(REG_TARGET, tg);
      csr_write(REG_HYST, hy);
      csr_write(REG_POWER, pw);
      csr_write(REG_CYCLES, cy);
      csr_write(REG_METHOD, me);
      csr_write(REG_TIMEOUT, to);
   endtask

   task automatic drain();
      while (pending_samples.size() != 0 || expected_results.size() != 0 || req_valid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Stimulus and end of run
   initial begin
      int phase_no;
      sh_target = 3200; sh_hyst = 16; sh_power = 255;
      sh_cycles = 5; sh_method = 0; sh_timeout = 600;
      tuner_restart();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: field extremes under default settings
      apply_settings(3200, 16, 255, 5, 0, 600);
      add_sample(0, -2048, 0);
      add_sample(0, 32767, 65535);
      add_sample(0, -1, 0);
      add_sample(0, 0, 1);
      add_sample(1, 32767, 65535);
      add_sample(0, 3300, 65535);
      add_sample(0, 3000, 65535);
      build_run(1);
      drain();

      phase_no = 0;
      while (item_total < 950) begin
         no_idle = ($urandom_range(0, 3) == 0);
         case (phase_no)
            0: apply_settings(0, 0, 0, 1, 0, 1);
            1: apply_settings(32767, 1023, 255, 2, 1, 65535);
            2: apply_settings(1600, 20, 200, 64, 1, 65535);
            3: apply_settings(100, 0, 255, 1, 0, 65535);
            default:
               apply_settings($urandom_range(0, 8000), $urandom_range(0, 300),
                              $urandom_range(0, 255), $urandom_range(1, 8),
                              $urandom_range(0, 1),
                              ($urandom_range(0, 5) == 0) ? $urandom_range(1, 30)
                                                         : $urandom_range(1000, 65535));
         endcase
         // some phases continue the running state with new registers
         build_run(phase_no < 4 || $urandom_range(0, 3) != 0);
         drain();
         phase_no++;
      end

      repeat (400) @(posedge clock);
      if (mismatches == 0 && unmatched == 0 && expected_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule
